// ===== rtl/u2cp_pkg.sv =====
// Package for the UTF-8 to code point decoder.
// Holds field widths, byte class bounds and the decode step result type.
// No dependencies.
`timescale 1ns / 1ps

package u2cp_pkg;

    localparam int BYTE_W = 8;
    localparam int CP_W   = 21;
    localparam int DUE_W  = 2;

    // Lead byte class bounds
    localparam logic [BYTE_W-1:0] ONE_BYTE_LIMIT   = 8'h80;
    localparam logic [BYTE_W-1:0] TWO_BYTE_LIMIT   = 8'hE0;
    localparam logic [BYTE_W-1:0] THREE_BYTE_LIMIT = 8'hF0;

    // Payload masks for lead and continuation bytes
    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'h1F;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'h0F;
    localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'h07;
    localparam logic [BYTE_W-1:0] CONT_MASK  = 8'h3F;

    // Continuation bytes due after each lead class
    localparam logic [DUE_W-1:0] DUE_NONE  = 2'd0;
    localparam logic [DUE_W-1:0] DUE_ONE   = 2'd1;
    localparam logic [DUE_W-1:0] DUE_TWO   = 2'd2;
    localparam logic [DUE_W-1:0] DUE_THREE = 2'd3;

    // Outcome of one decode step
    typedef struct packed {
        logic              emit;
        logic [CP_W-1:0]   cp_value;
        logic              last;
        logic [DUE_W-1:0]  bytes_due;
        logic [CP_W-1:0]   partial_point;
    } step_result_t;

endpackage

// ===== rtl/u2cp_input_stage.sv =====
// Input register of the UTF-8 decoder: holds one byte transaction.
// Depends on u2cp_pkg.
`timescale 1ns / 1ps

module u2cp_input_stage (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [u2cp_pkg::BYTE_W-1:0] in_byte,
    input  logic                        end_of_string,
    input  logic                        advance,
    output logic                        held_valid,
    output logic [u2cp_pkg::BYTE_W-1:0] held_byte,
    output logic                        held_eos
);
    import u2cp_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] byte_reg;
    logic              eos_reg;

    // Stall only while a held byte cannot move on
    assign in_stall = valid_reg && !advance;

    assign valid_next = (in_valid && !in_stall) ? 1'b1 :
                        (advance ? 1'b0 : valid_reg);

    // Hold valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture payload on each accepted transaction
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            byte_reg <= in_byte;
            eos_reg  <= end_of_string;
        end
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;
    assign held_eos   = eos_reg;

endmodule

// ===== rtl/u2cp_decode.sv =====
// Decode step of the UTF-8 decoder: classes a lead byte or merges a
// continuation byte into the partial code point. Depends on u2cp_pkg.
`timescale 1ns / 1ps

module u2cp_decode (
    input  logic [u2cp_pkg::BYTE_W-1:0] in_byte,
    input  logic                        eos,
    input  logic [u2cp_pkg::DUE_W-1:0]  bytes_due,
    input  logic [u2cp_pkg::CP_W-1:0]   partial_point,
    output u2cp_pkg::step_result_t      result
);
    import u2cp_pkg::*;

    logic [CP_W-1:0]  lead_point;
    logic [DUE_W-1:0] lead_due;
    logic [CP_W-1:0]  cont_bits;
    logic [CP_W-1:0]  merged;
    logic [DUE_W-1:0] cont_due;

    // Class the lead byte
    always_comb
    begin
        if (in_byte < ONE_BYTE_LIMIT)
        begin
            lead_point = {{(CP_W-BYTE_W){1'b0}}, in_byte};
            lead_due   = DUE_NONE;
        end
        else if (in_byte < TWO_BYTE_LIMIT)
        begin
            lead_point = {{(CP_W-BYTE_W){1'b0}}, in_byte & LEAD2_MASK} << 6;
            lead_due   = DUE_ONE;
        end
        else if (in_byte < THREE_BYTE_LIMIT)
        begin
            lead_point = {{(CP_W-BYTE_W){1'b0}}, in_byte & LEAD3_MASK} << 12;
            lead_due   = DUE_TWO;
        end
        else
        begin
            lead_point = {{(CP_W-BYTE_W){1'b0}}, in_byte & LEAD4_MASK} << 18;
            lead_due   = DUE_THREE;
        end
    end

    // Place continuation bits by the number still due
    always_comb
    begin
        cont_bits = {{(CP_W-BYTE_W){1'b0}}, in_byte & CONT_MASK};
        case (bytes_due)
            DUE_TWO:   cont_bits = cont_bits << 6;
            DUE_THREE: cont_bits = cont_bits << 12;
            default:   cont_bits = cont_bits;
        endcase
        merged   = partial_point | cont_bits;
        cont_due = bytes_due - DUE_ONE;
    end

    // Pick the outcome; clear state whenever a code point leaves
    always_comb
    begin
        if (bytes_due == DUE_NONE)
        begin
            result.emit     = (lead_due == DUE_NONE) || eos;
            result.cp_value = lead_point;
            result.last     = eos;
        end
        else
        begin
            result.emit     = (cont_due == DUE_NONE) || eos;
            result.cp_value = merged;
            result.last     = eos;
        end

        if (result.emit)
        begin
            result.bytes_due     = DUE_NONE;
            result.partial_point = '0;
        end
        else if (bytes_due == DUE_NONE)
        begin
            result.bytes_due     = lead_due;
            result.partial_point = lead_point;
        end
        else
        begin
            result.bytes_due     = cont_due;
            result.partial_point = merged;
        end
    end

endmodule

// ===== rtl/utf8_to_code_point_decoder_top.sv =====
// Top level of the UTF-8 to code point decoder.
// Depends on u2cp_pkg, u2cp_input_stage and u2cp_decode.
`timescale 1ns / 1ps

// Usage
// Input channel: in_valid / in_stall with in_byte and end_of_string, one
// UTF-8 byte per transaction. Output channel: out_valid / out_stall with
// cp_value and last; a transaction moves on an edge where valid is high and
// stall is low.
// A byte taken into the input register is decoded there and lands in the
// result register once that register is empty or draining, and the code
// point leaves when out_stall is low. One byte is taken every cycle unless
// the receiver stalls a waiting result; the rate is set by the single decode
// step between the input and result registers.
// Bytes that complete no code point produce no output transaction.
// A byte with end_of_string set closes the string: any unfinished sequence
// is emitted at once with its missing bits as zero and last set.
// Reset clears both valid flags and the sequence state (no bytes due, empty
// partial code point). While the receiver stalls a waiting result, it holds,
// at most one more byte is held in the input register, and then in_stall rises.

module utf8_to_code_point_decoder_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [u2cp_pkg::BYTE_W-1:0] in_byte,
    input  logic                        end_of_string,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [u2cp_pkg::CP_W-1:0]   cp_value,
    output logic                        last
);
    import u2cp_pkg::*;

    logic              advance;
    logic              held_valid;
    logic [BYTE_W-1:0] held_byte;
    logic              held_eos;
    step_result_t      step;

    logic [DUE_W-1:0]  bytes_due_reg;
    logic [CP_W-1:0]   partial_point_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [CP_W-1:0]   cp_value_reg;
    logic              last_reg;

    // Result register can take a new value when empty or draining
    assign advance = !out_valid_reg || !out_stall;

    u2cp_input_stage u_input (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_byte       (in_byte),
        .end_of_string (end_of_string),
        .advance       (advance),
        .held_valid    (held_valid),
        .held_byte     (held_byte),
        .held_eos      (held_eos)
    );

    u2cp_decode u_decode (
        .in_byte       (held_byte),
        .eos           (held_eos),
        .bytes_due     (bytes_due_reg),
        .partial_point (partial_point_reg),
        .result        (step)
    );

    assign out_valid_next = advance ? (held_valid && step.emit) : out_valid_reg;

    // Advance sequence state and result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_due_reg     <= DUE_NONE;
            partial_point_reg <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (advance && held_valid)
            begin
                bytes_due_reg     <= step.bytes_due;
                partial_point_reg <= step.partial_point;
            end
        end
    end

    // Load result payload when a code point leaves the decode step
    always_ff @(posedge clk)
    begin
        if (advance && held_valid && step.emit)
        begin
            cp_value_reg <= step.cp_value;
            last_reg     <= step.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign cp_value  = cp_value_reg;
    assign last      = last_reg;

endmodule
